// ===== src/hhe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhe_pkg
// Types, constants and character helpers shared by the host header extractor.
// ----------------------------------------------------------------------------
package hhe_pkg;

   localparam int KEY_LEN = 5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [15:0] SEARCH_LIMIT_RESET = 16'd8192;
   localparam logic [15:0] BYTES_SAT          = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_LINE,
      PH_SKIP,
      PH_SPACE,
      PH_HOST,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      STAT_FOUND,
      STAT_ENDED,
      STAT_HEADERS_END,
      STAT_LIMIT
   } status_type;

   typedef enum logic {
      KIND_CHAR,
      KIND_STATUS
   } kind_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] host_char;
      status_type status;
      logic [7:0] host_length;
      logic       end_of_run;
   } rsp_item_type;

   // up to two result beats per input byte, first one always used first
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } scan_out_type;

   function automatic logic [7:0] host_key(input logic [2:0] idx);
      logic [7:0] k;
      unique case (idx)
         3'd0:    k = 8'h68; // h
         3'd1:    k = 8'h6F; // o
         3'd2:    k = 8'h73; // s
         3'd3:    k = 8'h74; // t
         3'd4:    k = 8'h3A; // :
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic logic is_host_char(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h2D;
   endfunction

endpackage

// ===== src/hhe_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhe channels
// Valid/ready channel interfaces for request bytes, result beats and the
// search limit register write.
// ----------------------------------------------------------------------------
interface hhe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hhe_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] host_char;
   logic [1:0] status;
   logic [7:0] host_length;
   logic       end_of_run;

   modport source (output valid, output result_kind, output host_char, output status,
                   output host_length, output end_of_run, input ready);
   modport sink   (input valid, input result_kind, input host_char, input status,
                   input host_length, input end_of_run, output ready);
endinterface

interface hhe_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] search_limit;

   modport source (output valid, output search_limit, input ready);
   modport sink   (input valid, input search_limit, output ready);
endinterface

// ===== src/hhe_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhe_scan
// Per-byte scanner state machine: matches "host:" at line start, skips
// spaces, takes host characters and decides the final status.
// ----------------------------------------------------------------------------
module hhe_scan
   import hhe_pkg::*;
#(
   parameter int MAX_HOST_CHARS = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         beat,
   input  logic [7:0]   data_byte,
   input  logic         last_byte,
   input  logic [15:0]  search_limit,
   output scan_out_type scan_out
);

   localparam logic [7:0] MAX_CHARS = 8'(MAX_HOST_CHARS);
   localparam logic [2:0] KEY_LAST  = 3'(KEY_LEN - 1);

   phase_type   phase_ff,  phase_in,  phase_mid;
   logic [2:0]  match_ff,  match_in,  match_mid;
   logic        cr_ff,     cr_in,     cr_mid;
   logic        first_ff,  first_in,  first_mid;
   logic [15:0] bytes_ff,  bytes_in,  bytes_mid;
   logic [7:0]  name_ff,   name_in,   name_mid;
   logic        fin_pre_vld;
   status_type  fin_pre;
   logic        fin_vld;
   status_type  fin;
   logic        host_take;
   logic        char_ok;
   logic        emit;

   assign bytes_mid = (bytes_ff != BYTES_SAT) ? bytes_ff + 16'd1 : bytes_ff;

   // line, skip and space phases on the current byte
   always_comb begin
      phase_mid   = phase_ff;
      match_mid   = match_ff;
      cr_mid      = cr_ff;
      first_mid   = first_ff;
      fin_pre_vld = 1'b0;
      fin_pre     = STAT_FOUND;
      unique case (phase_ff)
         PH_LINE: begin
            if (cr_ff) begin
               cr_mid = 1'b0;
               if (data_byte == CH_LF) begin
                  fin_pre_vld = 1'b1;
                  fin_pre     = STAT_HEADERS_END;
               end else if (data_byte == CH_NUL) begin
                  fin_pre_vld = 1'b1;
                  fin_pre     = STAT_ENDED;
               end else begin
                  phase_mid = PH_SKIP;
               end
            end else if (match_ff == 3'd0 && !first_ff && data_byte == CH_LF) begin
               fin_pre_vld = 1'b1;
               fin_pre     = STAT_HEADERS_END;
            end else if (match_ff == 3'd0 && !first_ff && data_byte == CH_CR) begin
               cr_mid = 1'b1;
            end else if (data_byte == CH_NUL) begin
               fin_pre_vld = 1'b1;
               fin_pre     = STAT_ENDED;
            end else if (match_ff <= KEY_LAST && to_lower(data_byte) == host_key(match_ff)) begin
               if (match_ff == KEY_LAST) begin
                  match_mid = 3'd0;
                  phase_mid = PH_SPACE;
               end else begin
                  match_mid = match_ff + 3'd1;
               end
            end else if (data_byte == CH_LF) begin
               match_mid = 3'd0;
               first_mid = 1'b0;
            end else begin
               match_mid = 3'd0;
               phase_mid = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (data_byte == CH_NUL) begin
               fin_pre_vld = 1'b1;
               fin_pre     = STAT_ENDED;
            end else if (data_byte == CH_LF) begin
               phase_mid = PH_LINE;
               match_mid = 3'd0;
               first_mid = 1'b0;
            end
         end
         PH_SPACE: begin
            if (data_byte == CH_NUL) begin
               fin_pre_vld = 1'b1;
               fin_pre     = STAT_ENDED;
            end else if (data_byte != CH_SPACE) begin
               phase_mid = PH_HOST;
            end
         end
         default: begin
         end
      endcase
   end

   // host characters and the final status
   always_comb begin
      host_take = (phase_mid == PH_HOST) && !fin_pre_vld;
      char_ok   = is_host_char(data_byte) && (name_ff < MAX_CHARS);
      emit      = host_take && char_ok && (phase_ff != PH_DONE);
      name_mid  = emit ? name_ff + 8'd1 : name_ff;
      fin_vld   = 1'b0;
      fin       = STAT_FOUND;
      if (phase_ff == PH_DONE) begin
         fin_vld = 1'b0;
      end else if (fin_pre_vld) begin
         fin_vld = 1'b1;
         fin     = fin_pre;
      end else if (host_take && (!char_ok || name_mid >= MAX_CHARS)) begin
         fin_vld = 1'b1;
         fin     = STAT_FOUND;
      end else if (phase_mid != PH_HOST && bytes_mid >= search_limit) begin
         fin_vld = 1'b1;
         fin     = STAT_LIMIT;
      end else if (last_byte) begin
         fin_vld = 1'b1;
         fin     = (phase_mid == PH_HOST) ? STAT_FOUND : STAT_ENDED;
      end

      scan_out.push0 = beat && (emit || fin_vld);
      scan_out.push1 = beat && emit && fin_vld;

      scan_out.item1.result_kind = KIND_STATUS;
      scan_out.item1.host_char   = 8'h00;
      scan_out.item1.status      = fin;
      scan_out.item1.host_length = name_mid;
      scan_out.item1.end_of_run  = 1'b1;

      if (emit) begin
         scan_out.item0.result_kind = KIND_CHAR;
         scan_out.item0.host_char   = data_byte;
         scan_out.item0.status      = STAT_FOUND;
         scan_out.item0.host_length = 8'h00;
         scan_out.item0.end_of_run  = 1'b0;
      end else begin
         scan_out.item0 = scan_out.item1;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_mid;
      match_in = match_mid;
      cr_in    = cr_mid;
      first_in = first_mid;
      bytes_in = bytes_mid;
      name_in  = name_mid;
      if (phase_ff == PH_DONE || fin_vld) begin
         if (last_byte) begin
            phase_in = PH_LINE;
            match_in = 3'd0;
            cr_in    = 1'b0;
            first_in = 1'b1;
            bytes_in = 16'd0;
            name_in  = 8'd0;
         end else begin
            phase_in = PH_DONE;
            bytes_in = bytes_ff;
            name_in  = name_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE;
         match_ff <= 3'd0;
         cr_ff    <= 1'b0;
         first_ff <= 1'b1;
         bytes_ff <= 16'd0;
         name_ff  <= 8'd0;
      end else if (beat) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         cr_ff    <= cr_in;
         first_ff <= first_in;
         bytes_ff <= bytes_in;
         name_ff  <= name_in;
      end
   end

endmodule

// ===== src/hhe_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhe_rsp_fifo
// Four-entry result queue taking up to two beats per cycle and giving one while out_ready is high.
// ----------------------------------------------------------------------------
module hhe_rsp_fifo
   import hhe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  scan_out_type scan_out,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   rsp_item_type      mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [AW:0]       count_ff, count_in;
   logic              pop;
   logic [AW-1:0]     wr_next;

   assign room      = count_ff <= (AW + 1)'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ff + AW'(1);

   always_comb begin
      wr_in    = wr_ff + AW'(scan_out.push0) + AW'(scan_out.push1);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff + (AW + 1)'(scan_out.push0) + (AW + 1)'(scan_out.push1)
                 - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (scan_out.push0) begin
         mem_ff[wr_ff] <= scan_out.item0;
      end
      if (scan_out.push1) begin
         mem_ff[wr_next] <= scan_out.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/http_host_header_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_host_header_extractor
// Finds the Host header of an HTTP request and streams out its characters
// followed by one final status beat.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock while its queue has room. Each
// byte is decoded in the cycle it is accepted and yields zero, one or two
// result beats (a host character and/or the final status), which go into a
// four-entry output queue. A byte is accepted whenever the queue has two
// free entries, so with the result side taking a beat every cycle the input
// runs at one byte per clock; only the single byte that produces both a
// character and the status puts an extra beat into the queue. The search
// limit register is written through the csr channel, which is always ready,
// and should be changed only while the block is idle.
module http_host_header_extractor
   import hhe_pkg::*;
#(
   parameter int MAX_HOST_CHARS = 255
) (
   input  logic clock,
   input  logic reset,
   hhe_req_if.sink   req_if,
   hhe_rsp_if.source rsp_if,
   hhe_csr_if.sink   csr_if
);

   logic [15:0]  limit_ff;
   logic         room;
   logic         beat;
   scan_out_type scan_out;
   rsp_item_type out_item;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = room;
   assign beat         = req_if.valid && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SEARCH_LIMIT_RESET;
      end else if (csr_if.valid) begin
         limit_ff <= csr_if.search_limit;
      end
   end

   hhe_scan #(
      .MAX_HOST_CHARS (MAX_HOST_CHARS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .data_byte    (req_if.data_byte),
      .last_byte    (req_if.last_byte),
      .search_limit (limit_ff),
      .scan_out     (scan_out)
   );

   hhe_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .scan_out  (scan_out),
      .room      (room),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (out_item)
   );

   assign rsp_if.result_kind = out_item.result_kind;
   assign rsp_if.host_char   = out_item.host_char;
   assign rsp_if.status      = out_item.status;
   assign rsp_if.host_length = out_item.host_length;
   assign rsp_if.end_of_run  = out_item.end_of_run;

endmodule

// ===== verif/http_host_header_extractor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_host_header_extractor_tb
// Self-checking bench for the host header extractor. Request bytes are sent
// on the req channel while a local scanner model predicts every host
// character and final status beat. Each beat taken from the rsp channel is
// checked field by field against the oldest prediction. Stimulus covers
// directed corner cases, search limit settings, long host names, random
// well-formed and broken requests, random idling on both sides and a long
// result-side hold-off.
// ----------------------------------------------------------------------------
module http_host_header_extractor_tb;
   import hhe_pkg::*;

   localparam int MAX_NAME = 255;
   localparam logic [7:0] HOST_WORD [KEY_LEN] = '{"h", "o", "s", "t", ":"};
   localparam string NAME_SET =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-";

   logic clock;
   logic reset;

   hhe_req_if req_ch ();
   hhe_rsp_if rsp_ch ();
   hhe_csr_if csr_ch ();

   http_host_header_extractor #(
      .MAX_HOST_CHARS(MAX_NAME)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   // scanner model state
   phase_type   scan_state;
   int          key_pos;
   logic        cr_pending;
   logic        on_first_line;
   logic [15:0] byte_count;
   int          name_len;
   logic [15:0] limit_cfg;

   rsp_item_type host_beats_due [$];
   rsp_item_type due_beat;

   // bytes of the request being built, with their last flags
   logic [7:0] msg_bytes [$];
   logic       msg_last [$];

   int send_idle_pct;
   int stall_pct;
   int hold_request;
   int hold_left;

   int failures;
   int request_count;
   int scanned_bytes;
   int sent_bytes;
   int char_beats;
   int status_beats;
   int status_seen [4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("http_host_header_extractor test failed");
      $finish;
   end

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
   endfunction

   function automatic logic name_char(input logic [7:0] b);
      return (fold_case(b) >= "a" && fold_case(b) <= "z") ||
             (b >= "0" && b <= "9") || b == "." || b == "-";
   endfunction

   function automatic void rearm_scan();
      scan_state    = PH_LINE;
      key_pos       = 0;
      cr_pending    = 1'b0;
      on_first_line = 1'b1;
      byte_count    = '0;
      name_len      = 0;
   endfunction

   // works out the beats that one accepted byte causes
   function automatic void predict_host_beats(input logic [7:0] b, input logic last);
      logic         ended;
      status_type   verdict;
      rsp_item_type beat;
      ended   = 1'b0;
      verdict = STAT_FOUND;
      if (scan_state == PH_DONE) begin
         if (last)
            rearm_scan();
         return;
      end
      scanned_bytes++;
      if (byte_count != BYTES_SAT)
         byte_count++;

      case (scan_state)
         PH_LINE: begin
            if (cr_pending) begin
               cr_pending = 1'b0;
               if (b == CH_LF) begin
                  ended   = 1'b1;
                  verdict = STAT_HEADERS_END;
               end else if (b == CH_NUL) begin
                  ended   = 1'b1;
                  verdict = STAT_ENDED;
               end else begin
                  scan_state = PH_SKIP;
               end
            end else if (key_pos == 0 && !on_first_line && b == CH_LF) begin
               ended   = 1'b1;
               verdict = STAT_HEADERS_END;
            end else if (key_pos == 0 && !on_first_line && b == CH_CR) begin
               cr_pending = 1'b1;
            end else if (b == CH_NUL) begin
               ended   = 1'b1;
               verdict = STAT_ENDED;
            end else if (key_pos < KEY_LEN && fold_case(b) == HOST_WORD[key_pos]) begin
               key_pos++;
               if (key_pos >= KEY_LEN) begin
                  key_pos    = 0;
                  scan_state = PH_SPACE;
               end
            end else if (b == CH_LF) begin
               key_pos       = 0;
               on_first_line = 1'b0;
            end else begin
               key_pos    = 0;
               scan_state = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (b == CH_NUL) begin
               ended   = 1'b1;
               verdict = STAT_ENDED;
            end else if (b == CH_LF) begin
               scan_state    = PH_LINE;
               key_pos       = 0;
               on_first_line = 1'b0;
            end
         end
         PH_SPACE: begin
            if (b == CH_NUL) begin
               ended   = 1'b1;
               verdict = STAT_ENDED;
            end else if (b != CH_SPACE) begin
               scan_state = PH_HOST;
            end
         end
         default: ;
      endcase

      if (scan_state == PH_HOST && !ended) begin
         if (name_char(b) && name_len < MAX_NAME) begin
            beat = '{KIND_CHAR, b, STAT_FOUND, 8'd0, 1'b0};
            host_beats_due.push_back(beat);
            name_len++;
            if (name_len >= MAX_NAME)
               ended = 1'b1;
         end else begin
            ended = 1'b1;
         end
         verdict = STAT_FOUND;
      end

      // the byte's own meaning beats the limit, the limit beats the payload end
      if (!ended && scan_state != PH_HOST && byte_count >= limit_cfg) begin
         ended   = 1'b1;
         verdict = STAT_LIMIT;
      end
      if (!ended && last) begin
         ended   = 1'b1;
         verdict = (scan_state == PH_HOST) ? STAT_FOUND : STAT_ENDED;
      end

      if (ended) begin
         beat = '{KIND_STATUS, 8'd0, verdict, 8'(name_len), 1'b1};
         host_beats_due.push_back(beat);
         if (last)
            rearm_scan();
         else
            scan_state = PH_DONE;
      end
   endfunction

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void report_mismatch(input string field, input int due, input int got);
      $error("%s mismatch: expected %0d, got %0d", field, due, got);
      failures++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (host_beats_due.size() == 0) begin
            $error("result beat with nothing expected: kind %0d char %0d status %0d",
                   rsp_ch.result_kind, rsp_ch.host_char, rsp_ch.status);
            failures++;
         end else begin
            due_beat = host_beats_due.pop_front();
            if (rsp_ch.result_kind !== due_beat.result_kind)
               report_mismatch("result_kind", int'(due_beat.result_kind),
                               int'(rsp_ch.result_kind));
            if (rsp_ch.host_char !== due_beat.host_char)
               report_mismatch("host_char", int'(due_beat.host_char),
                               int'(rsp_ch.host_char));
            if (rsp_ch.status !== due_beat.status)
               report_mismatch("status", int'(due_beat.status), int'(rsp_ch.status));
            if (rsp_ch.host_length !== due_beat.host_length)
               report_mismatch("host_length", int'(due_beat.host_length),
                               int'(rsp_ch.host_length));
            if (rsp_ch.end_of_run !== due_beat.end_of_run)
               report_mismatch("end_of_run", int'(due_beat.end_of_run),
                               int'(rsp_ch.end_of_run));
            if (due_beat.result_kind == KIND_STATUS) begin
               status_beats++;
               status_seen[due_beat.status]++;
            end else begin
               char_beats++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predict_host_beats(b, last);
      sent_bytes++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (host_beats_due.size() != 0);
   endtask

   task automatic write_search_limit(input logic [15:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.search_limit <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      limit_cfg = value;
   endtask

   function automatic void add_byte(input logic [7:0] b, input logic last = 1'b0);
      msg_bytes.push_back(b);
      msg_last.push_back(last);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   function automatic void add_eol();
      if ($urandom_range(1))
         add_text("\r\n");
      else
         add_text("\n");
   endfunction

   function automatic void add_name_chars(input int count);
      for (int i = 0; i < count; i++)
         add_byte(NAME_SET[$urandom_range(NAME_SET.len() - 1)]);
   endfunction

   // other header line, sometimes starting like the host key
   function automatic void add_other_header();
      string prefixes [6];
      prefixes = '{"", "h", "ho", "hos", "host", "HOST"};
      add_text(prefixes[$urandom_range(5)]);
      for (int i = $urandom_range(6, 1); i > 0; i--)
         add_byte(8'($urandom_range("z", "a")));
      add_text(": ");
      for (int i = $urandom_range(12); i > 0; i--)
         add_byte(8'($urandom_range(126, 32)));
      add_eol();
   endfunction

   function automatic void add_host_key(input int spaces);
      logic [7:0] c;
      for (int i = 0; i < KEY_LEN; i++) begin
         c = HOST_WORD[i];
         if (c != ":" && $urandom_range(1))
            c = c - 8'd32;
         add_byte(c);
      end
      for (int i = 0; i < spaces; i++)
         add_byte(CH_SPACE);
   endfunction

   function automatic void build_request();
      int pick;
      for (int i = $urandom_range(7, 3); i > 0; i--)
         add_byte(8'($urandom_range("Z", "A")));
      add_text(" /");
      for (int i = $urandom_range(6); i > 0; i--)
         add_byte(8'($urandom_range("z", "a")));
      add_text(" HTTP/1.1");
      add_eol();
      for (int i = $urandom_range(3); i > 0; i--)
         add_other_header();
      if ($urandom_range(99) < 85) begin
         add_host_key($urandom_range(3));
         add_name_chars(($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(16));
         pick = $urandom_range(99);
         if (pick < 50) begin
            add_eol();
            for (int i = $urandom_range(2); i > 0; i--)
               add_other_header();
            add_eol();
            for (int i = $urandom_range(4); i > 0; i--)
               add_byte(8'($urandom_range(255)));
         end else if (pick < 65) begin
            for (int i = $urandom_range(4, 1); i > 0; i--)
               add_byte(8'($urandom_range(255)));
         end else if (pick < 75) begin
            add_byte(CH_NUL);
         end
      end else begin
         add_eol();
         for (int i = $urandom_range(4); i > 0; i--)
            add_byte(8'($urandom_range(255)));
      end
   endfunction

   task automatic send_message();
      int n;
      n = msg_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(msg_bytes[i], msg_last[i] | (i == n - 1));
      msg_bytes.delete();
      msg_last.delete();
      request_count++;
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_message();
   endtask

   // mostly well-formed requests, then raw noise and damaged requests
   task automatic send_random_request();
      int pick;
      int pos;
      pick = $urandom_range(99);
      if (pick < 70) begin
         build_request();
      end else if (pick < 85) begin
         for (int i = $urandom_range(20, 1); i > 0; i--)
            add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
         build_request();
         pos = $urandom_range(msg_bytes.size() - 1);
         case ($urandom_range(4))
            0: while (msg_bytes.size() > pos + 1) begin
                  void'(msg_bytes.pop_back());
                  void'(msg_last.pop_back());
               end
            1: msg_bytes[pos] = CH_NUL;
            2: msg_bytes[pos] = CH_CR;
            3: msg_bytes[pos] = 8'($urandom_range(255));
            default: msg_last[pos] = 1'b1;
         endcase
      end
      send_message();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_special_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      // name of mixed characters ended by a non-name byte, later bytes ignored
      add_text("hOsT:  Z9.-");
      add_byte(8'hFF);
      add_text("ab");
      send_message();
      // blank line right after the first line, then CR LF after a header
      send_text("\n\n");
      send_text("a\n\r\n");
      // NUL while searching
      add_byte(CH_NUL);
      send_message();
      // empty host name
      send_text("Host:;");
      // NUL while taking the name ends it with a found status
      add_text("host:q");
      add_byte(CH_NUL);
      send_message();
      // payload ends on a non-name byte, then on a name character
      send_text("HOST:\t");
      send_text("host: w");
   endtask

   task automatic test_search_limit();
      send_idle_pct = 10;
      stall_pct     = 10;
      write_search_limit(16'd1);
      send_text("host: a");
      add_byte(CH_NUL);
      send_message();
      send_text("\n");
      // NUL on the limit byte wins, the limit wins over the payload end
      write_search_limit(16'd3);
      add_text("ab");
      add_byte(CH_NUL);
      send_message();
      send_text("abc");
      send_text("host:   x");
      write_search_limit(16'hFFFF);
      send_random_request();
      for (int k = 0; k < 2; k++) begin
         write_search_limit(16'($urandom_range(60, 2)));
         send_random_request();
      end
      write_search_limit(SEARCH_LIMIT_RESET);
   endtask

   task automatic test_long_host();
      send_idle_pct = 5;
      stall_pct     = 5;
      // name cut at the cap, rest of the bytes ignored
      add_host_key(1);
      add_name_chars(MAX_NAME + 10);
      send_message();
      // payload ends one short of the cap
      add_host_key(0);
      add_name_chars(MAX_NAME - 1);
      send_message();
   endtask

   task automatic test_random_traffic(input int byte_goal, input int idle, input int stall);
      int start;
      send_idle_pct = idle;
      stall_pct     = stall;
      start = sent_bytes;
      while (sent_bytes - start < byte_goal)
         send_random_request();
   endtask

   task automatic test_result_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      wait_drained();
      hold_request = 200;
      add_text("GET / HTTP/1.1\r\nHost: ");
      add_name_chars(40);
      add_text("\r\n\r\n");
      send_message();
   endtask

   task automatic test_pause_until_drained();
      send_idle_pct = 20;
      stall_pct     = 40;
      for (int k = 0; k < 2; k++) begin
         send_random_request();
         wait_drained();
      end
   endtask

   initial begin
      int guard;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = '0;
      req_ch.last_byte    = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.search_limit = '0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_request        = 0;
      hold_left           = 0;
      failures            = 0;
      request_count       = 0;
      scanned_bytes       = 0;
      sent_bytes          = 0;
      char_beats          = 0;
      status_beats        = 0;
      status_seen         = '{0, 0, 0, 0};
      limit_cfg           = SEARCH_LIMIT_RESET;
      rearm_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_search_limit();
      test_long_host();
      test_random_traffic(40, 0, 0);
      write_search_limit(16'hFFFF);
      test_random_traffic(40, 77, 0);
      write_search_limit(16'($urandom_range(120, 16)));
      test_random_traffic(40, 0, 77);
      write_search_limit(SEARCH_LIMIT_RESET);
      test_random_traffic(40, 27, 27);
      test_result_hold_off();
      test_pause_until_drained();

      req_ch.valid <= 1'b0;
      guard = 0;
      while (host_beats_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (host_beats_due.size() != 0) begin
         $error("%0d expected result beats never arrived", host_beats_due.size());
         failures++;
      end

      $display("ran %0d requests, %0d bytes sent, %0d scanned, %0d host characters, %0d final beats",
               request_count, sent_bytes, scanned_bytes, char_beats, status_beats);
      $display("final status: found %0d, ended or NUL %0d, headers ended %0d, limit %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (failures == 0) begin
         $display("http_host_header_extractor test passed");
      end else begin
         $display("http_host_header_extractor test failed");
      end
      $finish;
   end

endmodule
